/* hw/rtl/elastic_audio_block_fifo_defines.svh */
// Assertion macros shared by the elastic audio block buffer modules
`ifndef ELASTIC_AUDIO_BLOCK_FIFO_DEFINES_SVH
`define ELASTIC_AUDIO_BLOCK_FIFO_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define EABF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("eabf: invariant violated");

// same-cycle implication
`define EABF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eabf: implication violated");

// next-cycle implication
`define EABF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eabf: next-cycle implication violated");

`endif

/* hw/rtl/eabf_pkg.sv */
// Types and constants of the elastic audio block buffer
`default_nettype none
package eabf_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int BLOCK_DEFAULT = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_GET = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] sample_out;
        logic               last_of_block;
        logic               underflow;
        logic [8:0]         fill_level;
        logic [31:0]        error_count;
        logic [14:0]        peak;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_PUT_FIRST,
        OP_PUT_MID,
        OP_PUT_LAST,
        OP_GET
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] sample;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET,
        S_SLIP
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/eabf_front.sv */
// Front end: takes input beats and tags put samples by block position
`default_nettype none
module eabf_front
    import eabf_pkg::*;
#(
    parameter int BLOCK = BLOCK_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_item_t item,
    input  wire logic     q_full,
    output logic          busy,
    output logic          push,
    output cmd_t          cmd
);

    localparam int PW = (BLOCK > 1) ? $clog2(BLOCK) : 1;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;

    assign busy = q_full;
    assign push = start && !q_full;

    always_comb
    begin
        cmd.sample = item.sample_in;
        pos_next   = pos_reg;
        if (item.mode == MODE_GET)
        begin
            cmd.op = OP_GET;
        end
        else
        begin
            if (pos_reg == '0)
                cmd.op = OP_PUT_FIRST;
            else if (pos_reg == PW'(BLOCK - 1))
                cmd.op = OP_PUT_LAST;
            else
                cmd.op = OP_PUT_MID;
            if (push)
                pos_next = (pos_reg == PW'(BLOCK - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule
`default_nettype wire

/* hw/rtl/eabf_cmd_queue.sv */
// Short command queue between the front end and the back end
`default_nettype none
`include "elastic_audio_block_fifo_defines.svh"
module eabf_cmd_queue
    import eabf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entries [QUEUE_DEPTH];
    logic [QAW-1:0]  wr_ptr_reg;
    logic [QAW-1:0]  wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg;
    logic [QAW-1:0]  rd_ptr_next;
    logic [QCW-1:0]  count_reg;
    logic [QCW-1:0]  count_next;

    assign full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `EABF_ASSERT_IMPL(a_no_pop_empty, pop, count_reg != '0)
    `EABF_ASSERT_IMPL(a_no_push_full, push, count_reg != QCW'(QUEUE_DEPTH))
    `EABF_ASSERT_ALWAYS(a_count_bound, count_reg <= QCW'(QUEUE_DEPTH))

endmodule
`default_nettype wire

/* hw/rtl/eabf_back.sv */
// Back end: sample memory, fill and slip control, result register
`default_nettype none
`include "elastic_audio_block_fifo_defines.svh"
module eabf_back
    import eabf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int BLOCK = BLOCK_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire cmd_t head,
    output logic      pop,
    output logic      done,
    output out_item_t result
);

    localparam int AW        = $clog2(DEPTH);
    localparam int HW        = $clog2(DEPTH + 1);
    localparam int CW        = (BLOCK > 1) ? $clog2(BLOCK) : 1;
    localparam int FW        = 9;
    localparam int LOW_MARK  = 2 * BLOCK - 2;
    localparam int HIGH_MARK = DEPTH - BLOCK + 2;

    logic signed [15:0] mem [DEPTH];

    state_t             state_reg, state_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [HW-1:0]      held_reg, held_next;
    logic [31:0]        err_reg, err_next;
    logic [14:0]        peak_reg, peak_next;
    logic signed [15:0] prev_reg, prev_next;
    logic               acc_reg, acc_next;
    logic               uf_reg, uf_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               done_reg, done_next;
    out_item_t          res_reg, res_next;
    logic               from_mem_reg, from_mem_next;
    logic signed [15:0] rd_data_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [15:0] mem_wdata;
    logic               mem_re;
    logic               room;
    logic               acc;
    logic               uf_now;
    logic [HW+FW-1:0]   held_ext;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign room     = (int'(held_reg) + BLOCK <= DEPTH);
    assign uf_now   = (int'(held_reg) < BLOCK);
    assign held_ext = {{FW{1'b0}}, held_next};

    always_comb
    begin
        state_next    = state_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        held_next     = held_reg;
        err_next      = err_reg;
        peak_next     = peak_reg;
        prev_next     = prev_reg;
        acc_next      = acc_reg;
        uf_next       = uf_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        from_mem_next = 1'b0;
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = wr_ptr_reg;
        mem_wdata     = head.sample;
        mem_re        = 1'b0;
        acc           = acc_reg;
        res_next      = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    unique case (head.op)
                        OP_PUT_FIRST, OP_PUT_MID, OP_PUT_LAST:
                        begin
                            if (head.op == OP_PUT_FIRST)
                            begin
                                acc      = room;
                                acc_next = room;
                                if (!room)
                                    err_next = err_reg + 1'b1;
                            end
                            if (acc)
                            begin
                                mem_we      = 1'b1;
                                prev_next   = head.sample;
                                wr_ptr_next = ptr_inc(wr_ptr_reg);
                                if (!head.sample[15] && (head.sample[14:0] > peak_reg))
                                    peak_next = head.sample[14:0];
                            end
                            if (head.op == OP_PUT_LAST)
                            begin
                                if (acc)
                                    held_next = held_reg + HW'(BLOCK);
                                state_next = S_SLIP;
                            end
                        end
                        OP_GET:
                        begin
                            uf_next = uf_now;
                            if (!uf_now)
                            begin
                                held_next   = held_reg - HW'(BLOCK);
                                mem_re      = 1'b1;
                                rd_ptr_next = ptr_inc(rd_ptr_reg);
                            end
                            done_next     = 1'b1;
                            from_mem_next = !uf_now;
                            cnt_next      = CW'(1);
                            state_next    = S_GET;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                if (!uf_reg)
                begin
                    mem_re      = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                end
                done_next     = 1'b1;
                from_mem_next = !uf_reg;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(BLOCK - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_SLIP:
            begin
                // level nudge after commit; held_reg already includes the block
                mem_wdata = prev_reg;
                if (acc_reg)
                begin
                    if (int'(held_reg) < LOW_MARK)
                    begin
                        if (int'(held_reg) < DEPTH)
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            held_next   = held_reg + 1'b1;
                        end
                        err_next = err_reg + 1'b1;
                    end
                    else if (int'(held_reg) > HIGH_MARK)
                    begin
                        wr_ptr_next = ptr_dec(wr_ptr_reg);
                        held_next   = held_reg - 1'b1;
                        err_next    = err_reg + 1'b1;
                    end
                end
                acc_next   = 1'b0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            res_next.result_kind   = (state_reg == S_SLIP) ? KIND_STATUS : KIND_SAMPLE;
            res_next.sample_out    = '0;
            res_next.last_of_block = (state_reg == S_SLIP) ||
                                     ((state_reg == S_GET) && (cnt_reg == CW'(BLOCK - 1)));
            res_next.underflow     = (state_reg == S_SLIP) ? 1'b0 : uf_next;
            res_next.fill_level    = held_ext[FW-1:0];
            res_next.error_count   = err_next;
            res_next.peak          = peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[rd_ptr_reg];
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            held_reg     <= '0;
            err_reg      <= '0;
            peak_reg     <= '0;
            prev_reg     <= '0;
            acc_reg      <= 1'b0;
            uf_reg       <= 1'b0;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
            from_mem_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            held_reg     <= held_next;
            err_reg      <= err_next;
            peak_reg     <= peak_next;
            prev_reg     <= prev_next;
            acc_reg      <= acc_next;
            uf_reg       <= uf_next;
            cnt_reg      <= cnt_next;
            done_reg     <= done_next;
            from_mem_reg <= from_mem_next;
        end
    end

    always_comb
    begin
        result            = res_reg;
        result.sample_out = from_mem_reg ? rd_data_reg : 16'sd0;
    end

    assign done = done_reg;

    `EABF_ASSERT_ALWAYS(a_held_bound, int'(held_reg) <= DEPTH)
    `EABF_ASSERT_IMPL(a_status_after_slip, done_reg && (res_reg.result_kind == KIND_STATUS), $past(state_reg) == S_SLIP)
    `EABF_ASSERT_NEXT(a_get_emits, state_reg == S_GET, done_reg)

endmodule
`default_nettype wire

/* hw/rtl/elastic_audio_block_fifo.sv */
// Top level of the elastic audio block buffer
//
// Command channel: an item is taken at a clock edge with start high and busy
// low. mode 0 carries one put sample; every BLOCK put beats form one block.
// mode 1 asks for one get block of BLOCK samples.
// Result channel: each result beat is on result for exactly one cycle with
// done high; the receiver has no way to hold results off.
// Items pass through a two-entry command queue to the back end, which owns
// the sample memory (one write and one registered read port).
// In the back end a put sample of an accepted block is written to memory; the
// last put of a block also passes a level nudge step after the commit, which
// issues its status beat. A get gives BLOCK sample beats back to back, each read
// from memory, or zeros with underflow set when too few samples are held.
// busy is high while the queue is full, so puts stream at one per cycle while
// the back end keeps up, and stall while it works through a get.
// Reset clears all pointers, counts and the peak; the memory is not cleared
// and no entry is read before it has been written.
`default_nettype none
module elastic_audio_block_fifo
    import eabf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int BLOCK = BLOCK_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_item_t item,
    output logic          busy,
    output logic          done,
    output out_item_t     result
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head;

    eabf_front #(
        .BLOCK (BLOCK)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .q_full (q_full),
        .busy   (busy),
        .push   (push),
        .cmd    (push_cmd)
    );

    eabf_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    eabf_back #(
        .DEPTH (DEPTH),
        .BLOCK (BLOCK)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule
`default_nettype wire
